>>> sv/skn_pkg.sv
// skn_pkg: beat types, character constants and byte classifier for the
// search key normalizer. No dependencies.
package skn_pkg;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       is_end;
    } t_in_beat;

    typedef struct packed {
        logic [6:0] out_char;
        logic       is_last;
    } t_out_beat;

    // Results produced by one accepted input beat (0, 1 or 2).
    typedef struct packed {
        logic [1:0] cnt;
        t_out_beat  first;
        t_out_beat  second;
    } t_push;

    typedef enum logic [1:0] {
        CLS_DROP,
        CLS_SPACE,
        CLS_CHAR
    } t_cls;

    typedef struct packed {
        t_cls       cls;
        logic [6:0] ch;
    } t_map;

    localparam logic [8:0] CAP_RESET = 9'd64;
    localparam logic [6:0] CH_SPACE  = 7'h20;
    localparam logic [6:0] CH_NUL    = 7'h00;
    localparam logic [7:0] B_DASH    = 8'h2D;
    localparam logic [7:0] B_APOS    = 8'h27;
    localparam logic [7:0] B_RQUOTE  = 8'h92;
    localparam logic [7:0] B_UP_A    = 8'h41;
    localparam logic [7:0] B_UP_Z    = 8'h5A;
    localparam logic [7:0] B_LO_A    = 8'h61;
    localparam logic [7:0] B_LO_Z    = 8'h7A;
    localparam logic [7:0] B_DIG_0   = 8'h30;
    localparam logic [7:0] B_DIG_9   = 8'h39;
    localparam logic [7:0] CASE_BIT  = 8'h20;

    // Output queue geometry.
    localparam int QDEPTH  = 4;
    localparam int QPTR_W  = $clog2(QDEPTH);
    localparam int QCNT_W  = $clog2(QDEPTH + 1);

    function automatic t_map map_byte(input logic [7:0] b);
        t_map m;
        m.cls = CLS_SPACE;
        m.ch  = CH_SPACE;
        if (b >= B_UP_A && b <= B_UP_Z) begin
            m.cls = CLS_CHAR;
            m.ch  = 7'(b | CASE_BIT);
        end else if ((b >= B_LO_A && b <= B_LO_Z) || (b >= B_DIG_0 && b <= B_DIG_9) ||
                     b == B_DASH) begin
            m.cls = CLS_CHAR;
            m.ch  = b[6:0];
        end else if (b == B_APOS || b == B_RQUOTE) begin
            m.cls = CLS_DROP;
            m.ch  = CH_NUL;
        end
        return m;
    endfunction

endpackage

>>> sv/skn_core.sv
// skn_core: key state and per-beat result generation.
// Depends on skn_pkg.
module skn_core (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [8:0]        i_cfg_wdata,
    input  logic              i_accept,
    input  skn_pkg::t_in_beat i_beat,
    output skn_pkg::t_push    o_push
);
    import skn_pkg::*;

    logic [8:0] r_cap, n_cap;
    logic       r_last_sp, n_last_sp;
    logic       r_pend, n_pend;
    logic [8:0] r_count, n_count;
    logic       r_full, n_full;
    t_map       w_map;
    logic       w_full_now;

    assign w_map      = map_byte(i_beat.in_byte);
    // 10-bit compare so count + 1 never wraps
    assign w_full_now = r_full || ({1'b0, r_count} + 10'd1 >= {1'b0, r_cap});

    always_comb begin
        n_cap     = i_cfg_we ? i_cfg_wdata : r_cap;
        n_last_sp = r_last_sp;
        n_pend    = r_pend;
        n_count   = r_count;
        n_full    = r_full;
        o_push    = '0;
        if (i_accept) begin
            if (i_beat.is_end || i_beat.in_byte == 8'd0) begin
                o_push.cnt          = 2'd1;
                o_push.first        = '{out_char: CH_NUL, is_last: 1'b1};
                n_last_sp           = 1'b1;
                n_pend              = 1'b0;
                n_count             = '0;
                n_full              = 1'b0;
            end else begin
                n_full = w_full_now;
                if (!w_full_now) begin
                    case (w_map.cls)
                        CLS_SPACE: begin
                            if (!r_last_sp) begin
                                n_last_sp = 1'b1;
                                n_pend    = 1'b1;
                                n_count   = r_count + 9'd1;
                            end
                        end
                        CLS_CHAR: begin
                            n_last_sp = 1'b0;
                            n_pend    = 1'b0;
                            n_count   = r_count + 9'd1;
                            if (r_pend) begin
                                o_push.cnt    = 2'd2;
                                o_push.first  = '{out_char: CH_SPACE, is_last: 1'b0};
                                o_push.second = '{out_char: w_map.ch, is_last: 1'b0};
                            end else begin
                                o_push.cnt    = 2'd1;
                                o_push.first  = '{out_char: w_map.ch, is_last: 1'b0};
                            end
                        end
                        default: ;
                    endcase
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap     <= CAP_RESET;
            r_last_sp <= 1'b1;
            r_pend    <= 1'b0;
            r_count   <= '0;
            r_full    <= 1'b0;
        end else begin
            r_cap     <= n_cap;
            r_last_sp <= n_last_sp;
            r_pend    <= n_pend;
            r_count   <= n_count;
            r_full    <= n_full;
        end
    end

endmodule

>>> sv/skn_outq.sv
// skn_outq: small result queue taking up to two beats per cycle, one out while i_stall is low.
// Depends on skn_pkg.
module skn_outq (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  skn_pkg::t_push     i_push,
    output logic               o_busy,
    output logic               o_valid,
    input  logic               i_stall,
    output skn_pkg::t_out_beat o_data
);
    import skn_pkg::*;

    t_out_beat          r_mem [QDEPTH];
    logic [QPTR_W-1:0]  r_rd_ptr, n_rd_ptr;
    logic [QPTR_W-1:0]  r_wr_ptr, n_wr_ptr;
    logic [QCNT_W-1:0]  r_count, n_count;
    logic               w_pop;
    logic [QPTR_W-1:0]  w_wr_next;

    assign o_valid   = r_count != '0;
    assign o_data    = r_mem[r_rd_ptr];
    // busy while fewer than two free slots remain
    assign o_busy    = r_count > QCNT_W'(QDEPTH - 2);
    assign w_pop     = o_valid && !i_stall;
    assign w_wr_next = r_wr_ptr + QPTR_W'(1);

    always_comb begin
        n_rd_ptr = r_rd_ptr + QPTR_W'(w_pop);
        n_wr_ptr = r_wr_ptr + QPTR_W'(i_push.cnt);
        n_count  = r_count + QCNT_W'(i_push.cnt) - QCNT_W'(w_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_ptr <= '0;
            r_wr_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_rd_ptr <= n_rd_ptr;
            r_wr_ptr <= n_wr_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push.cnt != 2'd0) begin
            r_mem[r_wr_ptr] <= i_push.first;
        end
        if (i_push.cnt == 2'd2) begin
            r_mem[w_wr_next] <= i_push.second;
        end
    end

endmodule

>>> sv/search_key_normalizer.sv
// search_key_normalizer: byte stream to normalized search key characters.
// Throughput: one input beat per cycle while o_stall is low; output one beat per
// cycle while i_stall is low, set by the single output port of the result queue
// (a beat may make two results). Reset (synchronous, active low) empties the
// queue, clears key state and sets key_capacity to 64. Depends on skn_pkg,
// skn_core, skn_outq.
module search_key_normalizer (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // configuration: key_capacity
    input  logic               i_cfg_we,
    input  logic [8:0]         i_cfg_wdata,
    // input channel
    input  logic               i_valid,
    output logic               o_stall,
    input  skn_pkg::t_in_beat  i_data,
    // output channel
    output logic               o_valid,
    input  logic               i_stall,
    output skn_pkg::t_out_beat o_data
);
    import skn_pkg::*;

    t_push w_push;
    logic  w_accept;
    logic  w_busy;

    // Stall comes from registered queue fill only, so it never looks at valid.
    assign o_stall  = w_busy;
    assign w_accept = i_valid && !w_busy;

    // Key state: lowering, space collapsing, held space, capacity limit.
    // Results of an accepted beat go straight into the queue next edge.
    skn_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_accept    (w_accept),
        .i_beat      (i_data),
        .o_push      (w_push)
    );

    // Result queue parts the two sides: input keeps flowing while a
    // result waits, and a held space plus its character drain in order.
    skn_outq u_outq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .o_busy  (w_busy),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_data  (o_data)
    );

endmodule

>>> sv/skn_checker.sv
// skn_checker: port-level assertions for search_key_normalizer, with bind.
// Depends on skn_pkg.
module skn_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_valid,
    input logic               o_stall,
    input skn_pkg::t_in_beat  i_data,
    input logic               o_valid,
    input logic               i_stall,
    input skn_pkg::t_out_beat o_data
);
    import skn_pkg::*;

    // stalled output beat holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_data))
        else $error("output beat changed under stall");

    // input stall only when results are backed up
    a_stall_needs_backlog: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> o_valid)
        else $error("stall with empty output");

    // end beat into an empty queue shows terminator next cycle
    a_end_term: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall && i_data.is_end && !o_valid |=> o_valid && o_data.is_last)
        else $error("terminator missing after end beat");

    // terminator carries zero; characters never do
    a_term_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_data.is_last == (o_data.out_char == CH_NUL)))
        else $error("terminator flag and character disagree");

endmodule

bind search_key_normalizer skn_checker u_skn_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .i_valid (i_valid),
    .o_stall (o_stall),
    .i_data  (i_data),
    .o_valid (o_valid),
    .i_stall (i_stall),
    .o_data  (o_data)
);

>>> tb/tb_search_key_normalizer.sv
// tb_search_key_normalizer: self-checking bench for the search key normalizer.
// Runs directed and random byte beats through a key predictor and checks every output beat.
// Depends on skn_pkg and search_key_normalizer.
module tb_search_key_normalizer;
    import skn_pkg::*;

    localparam int CYCLE_LIMIT = 200000;
    localparam int SETTLE_CYCLES = 8;

    // Tracks key state and holds the characters the block still owes us.
    class key_checker;
        t_out_beat  want_q[$];
        logic [8:0] capacity;
        bit         last_space;
        bit         space_held;
        logic [8:0] count;
        bit         full;
        int         errors;

        function new();
            capacity = CAP_RESET;
            errors   = 0;
            clear_key();
        endfunction

        function void clear_key();
            last_space = 1'b1;
            space_held = 1'b0;
            count      = '0;
            full       = 1'b0;
        endfunction

        function void set_capacity(logic [8:0] v);
            capacity = v;
        endfunction

        // Predicts the output beats for one accepted input beat.
        function void take_byte(t_in_beat b);
            t_out_beat  r;
            logic [6:0] ch;
            if (b.is_end || b.in_byte == 8'h00) begin
                r.out_char = CH_NUL;
                r.is_last  = 1'b1;
                want_q = {want_q, r};
                clear_key();
                return;
            end
            // capacity test runs before the byte is classified; full latches
            if (int'(count) + 1 >= int'(capacity))
                full = 1'b1;
            if (full)
                return;
            if (b.in_byte >= B_UP_A && b.in_byte <= B_UP_Z) begin
                ch = 7'(b.in_byte - B_UP_A + B_LO_A);
            end else if ((b.in_byte >= B_LO_A && b.in_byte <= B_LO_Z) ||
                         (b.in_byte >= B_DIG_0 && b.in_byte <= B_DIG_9) ||
                         b.in_byte == B_DASH) begin
                ch = b.in_byte[6:0];
            end else if (b.in_byte == B_APOS || b.in_byte == B_RQUOTE) begin
                return;
            end else begin
                // space class: collapse runs, hold the space until a character
                if (last_space)
                    return;
                last_space = 1'b1;
                space_held = 1'b1;
                count      = count + 9'd1;
                return;
            end
            last_space = 1'b0;
            if (space_held) begin
                r.out_char = CH_SPACE;
                r.is_last  = 1'b0;
                want_q = {want_q, r};
                space_held = 1'b0;
            end
            r.out_char = ch;
            r.is_last  = 1'b0;
            want_q = {want_q, r};
            count = count + 9'd1;
        endfunction

        function void match_char(t_out_beat got);
            t_out_beat w;
            if (want_q.size() == 0) begin
                $error("unexpected output beat: out_char %0h is_last %0b",
                       got.out_char, got.is_last);
                errors++;
                return;
            end
            w = want_q.pop_front();
            if (got.out_char !== w.out_char) begin
                $error("out_char mismatch: expected %0h actual %0h", w.out_char, got.out_char);
                errors++;
            end
            if (got.is_last !== w.is_last) begin
                $error("is_last mismatch: expected %0b actual %0b", w.is_last, got.is_last);
                errors++;
            end
        endfunction
    endclass

    logic       i_clk       = 1'b0;
    logic       i_rst_n     = 1'b0;
    logic       i_cfg_we    = 1'b0;
    logic [8:0] i_cfg_wdata = '0;
    logic       i_valid     = 1'b0;
    logic       o_stall;
    t_in_beat   i_data      = '0;
    logic       o_valid;
    logic       i_stall     = 1'b0;
    t_out_beat  o_data;

    key_checker sb = new();

    int cycles    = 0;
    int gap_pct   = 0;     // chance of an input idle burst before a beat
    bit quiet     = 1'b0;  // no idling on either side
    int stall_left = 0;

    search_key_normalizer u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_data      (i_data),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_data      (o_data)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // Monitor: values read here are the ones present just before the edge,
    // so both handshakes are judged exactly as the block sees them.
    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
        if (i_rst_n) begin
            if (o_valid && !i_stall)
                sb.match_char(o_data);
            if (i_valid && !o_stall)
                sb.take_byte(i_data);
        end
    end

    // Output back-pressure: stall bursts of random length at random.
    always @(posedge i_clk) begin
        logic nxt;
        nxt = 1'b0;
        if (i_rst_n && !quiet) begin
            if (stall_left > 0) begin
                stall_left--;
                nxt = 1'b1;
            end else if ($urandom_range(0, 3) == 0) begin
                stall_left = $urandom_range(0, 4);
                nxt = 1'b1;
            end
        end else begin
            stall_left = 0;
        end
        i_stall <= nxt;
    end

    // Every task below starts and ends right after a rising edge.
    task automatic send_beat(input t_in_beat b);
        int gap;
        if (!quiet && $urandom_range(0, 99) < gap_pct) begin
            gap = $urandom_range(1, 5);
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_data  <= b;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
    endtask

    task automatic send_byte(input logic [7:0] v);
        t_in_beat b;
        b.in_byte = v;
        b.is_end  = 1'b0;
        send_beat(b);
    endtask

    task automatic send_end(input logic [7:0] v);
        t_in_beat b;
        b.in_byte = v;
        b.is_end  = 1'b1;
        send_beat(b);
    endtask

    // Let the monitor see the last accepted beat, then wait until every
    // predicted beat is out and the block shows nothing pending.
    task automatic wait_drained();
        i_valid <= 1'b0;
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        while (sb.want_q.size() != 0 || o_valid) @(posedge i_clk);
    endtask

    task automatic write_capacity(input logic [8:0] v);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= v;
        @(posedge i_clk);
        sb.set_capacity(v);
        i_cfg_we    <= 1'b0;
    endtask

    // Mostly key-like bytes; the tail covers every byte value except zero.
    function automatic logic [7:0] rand_key_byte();
        int r;
        r = $urandom_range(0, 99);
        if (r < 35)      return 8'($urandom_range(B_LO_A, B_LO_Z));
        else if (r < 50) return 8'($urandom_range(B_UP_A, B_UP_Z));
        else if (r < 60) return 8'($urandom_range(B_DIG_0, B_DIG_9));
        else if (r < 64) return B_DASH;
        else if (r < 78) return 8'h20;
        else if (r < 84) return 8'($urandom_range(9, 13));
        else if (r < 88) return ($urandom_range(0, 1) != 0) ? B_APOS : B_RQUOTE;
        else             return 8'($urandom_range(1, 255));
    endfunction

    // Keys of random content; some long enough to hit capacity, some pure noise.
    // A phase may stop mid-key, so the next capacity lands inside a key.
    task automatic run_phase(input int n_items);
        int  sent;
        int  len;
        bit  noise;
        sent = 0;
        while (sent < n_items) begin
            noise = ($urandom_range(0, 6) == 0);
            len = ($urandom_range(0, 11) == 0) ? $urandom_range(100, 300)
                                               : $urandom_range(1, 30);
            for (int k = 0; k < len && sent < n_items; k++) begin
                send_byte(noise ? 8'($urandom_range(0, 255)) : rand_key_byte());
                sent++;
            end
            if (sent < n_items) begin
                if ($urandom_range(0, 1) != 0)
                    send_end(8'($urandom_range(0, 255)));
                else
                    send_byte(8'h00);
                sent++;
            end
        end
    endtask

    initial begin
        logic [8:0] caps [7];
        caps = '{9'd1, 9'd256, 9'd0, 9'd2, 9'd17, 9'd511, 9'd64};
        caps[4] = 9'($urandom_range(3, 40));

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: reset capacity, every byte class, collapse and trim.
        gap_pct = 20;
        send_byte(8'h20);          // leading space dropped
        send_byte(8'h41);          // upper case lowered
        send_byte(8'h62);
        send_byte(B_APOS);         // dropped
        send_byte(8'h5A);
        send_byte(8'h09);          // tab becomes space
        send_byte(8'h20);          // collapses into the held space
        send_byte(B_DASH);
        send_byte(8'h30);
        send_byte(8'h39);
        send_byte(B_RQUOTE);       // dropped
        send_byte(8'h7E);
        send_byte(8'hFF);
        send_byte(8'h71);
        send_byte(8'h80);
        send_end(8'h78);           // end beat, byte ignored, held space lost
        send_byte(8'h00);          // empty key
        send_byte(8'h4D);
        send_byte(8'h0A);          // trailing space trimmed
        send_byte(8'h00);
        wait_drained();

        // Tiny key: the held space fills it and is never sent.
        write_capacity(9'd3);
        send_byte(8'h61);
        send_byte(8'h20);
        send_byte(8'h62);
        send_byte(8'h63);
        send_end(8'h00);
        wait_drained();

        // Random phases over the capacity extremes; the last runs with no idling.
        for (int p = 0; p < 7; p++) begin
            write_capacity(caps[p]);
            gap_pct = $urandom_range(0, 40);
            quiet   = (p == 6);
            run_phase(110);
            wait_drained();
        end

        if (sb.errors == 0 && sb.want_q.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
